FILE: sv/tape_device_controller_macros.svh
// assertion macros shared by the tape controller rtl
// depends on: nothing; users supply clk and rst_n in scope
`ifndef TAPE_DEVICE_CONTROLLER_MACROS_SVH
`define TAPE_DEVICE_CONTROLLER_MACROS_SVH

// property must hold at every clock edge outside reset
`define TDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle forces consequent in the next cycle
`define TDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tdc_pkg.sv
// shared types, codes and defaults of the tape device controller
// depends on: nothing
`timescale 1ns / 1ps

package tdc_pkg;

  // parameter defaults
  localparam int NUM_TAPES_DEF        = 8;
  localparam int BLOCK_INDEX_BITS_DEF = 32;

  localparam int TAPE_IDX_W = 3;
  localparam int OP_W       = 8;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int ADDR_W     = 32;
  localparam int IRQ_W      = 8;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // item kinds
  localparam logic KIND_MAILBOX = 1'b0;
  localparam logic KIND_SERVICE = 1'b1;

  // mailbox operation codes
  localparam op_t OP_RESET    = 8'd0;
  localparam op_t OP_ACK      = 8'd1;
  localparam op_t OP_READREGS = 8'd2;
  localparam op_t OP_SKIP     = 8'd3;
  localparam op_t OP_READ     = 8'd4;
  localparam op_t OP_WRITE    = 8'd5;

  // stored last command codes
  localparam cmd_t CMD_RESET = 3'd0;
  localparam cmd_t CMD_ACK   = 3'd1;
  localparam cmd_t CMD_SKIP  = 3'd3;
  localparam cmd_t CMD_READ  = 3'd4;
  localparam cmd_t CMD_WRITE = 3'd5;

  // drive status codes
  localparam status_t ST_ABSENT  = 3'd0;
  localparam status_t ST_READY   = 3'd1;
  localparam status_t ST_BUSY    = 3'd2;
  localparam status_t ST_RDERR   = 3'd3;
  localparam status_t ST_ILLEGAL = 3'd4;

  // one input item
  typedef struct packed {
    logic                  command;
    logic [TAPE_IDX_W-1:0] tape_index;
    op_t                   tape_op;
    logic [ADDR_W-1:0]     buffer_address;
    logic                  transfer_ok;
  } item_t;

  // decision of the command unit for one item
  typedef struct packed {
    status_t status;
    cmd_t    cmd;
    logic    load_addr;
    logic    blk_inc;
    logic    int_set;
    logic    int_clr;
    logic    written;
    logic    timer;
    logic    xreq;
    logic    xwr;
  } exec_t;

endpackage

FILE: sv/tdc_exec.sv
// command decode and status update for one tape item
// depends on: tdc_pkg
`timescale 1ns / 1ps

module tdc_exec import tdc_pkg::*; (
  input  item_t   item,
  input  logic    present,
  input  status_t cur_status,
  input  cmd_t    cur_cmd,
  output exec_t   ex
);

  logic busy;

  assign busy = (cur_status == ST_BUSY);

  // decide new status, command and side effects
  always_comb begin
    ex           = '0;
    ex.status    = cur_status;
    ex.cmd       = cur_cmd;
    if (!present) begin
      // absent drive only answers read registers
      ex.written = (item.command == KIND_MAILBOX) && (item.tape_op == OP_READREGS);
    end else if (item.command == KIND_MAILBOX) begin
      ex.written = 1'b1;
      unique case (item.tape_op) inside
        OP_RESET: begin
          ex.cmd    = CMD_RESET;
          ex.status = ST_READY;
        end
        OP_ACK: begin
          if (!busy) begin
            ex.cmd     = CMD_ACK;
            ex.status  = ST_READY;
            ex.int_clr = 1'b1;
          end
        end
        OP_READREGS: begin
        end
        OP_SKIP, OP_READ, OP_WRITE: begin
          if (!busy) begin
            ex.cmd       = item.tape_op[CMD_W-1:0];
            ex.load_addr = (item.tape_op != OP_SKIP);
            ex.status    = ST_BUSY;
            ex.timer     = 1'b1;
          end
        end
        default: begin
          ex.status = ST_ILLEGAL;
        end
      endcase
    end else if (busy) begin
      // service finishes the pending command
      if (cur_cmd == CMD_SKIP) begin
        ex.blk_inc = 1'b1;
        ex.status  = ST_READY;
        ex.int_set = 1'b1;
        ex.written = 1'b1;
      end else if (cur_cmd == CMD_READ || cur_cmd == CMD_WRITE) begin
        ex.xreq    = 1'b1;
        ex.xwr     = (cur_cmd == CMD_WRITE);
        ex.status  = item.transfer_ok ? ST_READY : ST_RDERR;
        ex.int_set = item.transfer_ok;
        ex.written = 1'b1;
      end
    end
  end

endmodule

FILE: sv/tape_device_controller.sv
// tape device controller top level: item register, per-drive state, result register
// depends on: tdc_pkg, tdc_exec, tape_device_controller_macros.svh
//
// Usage
//   in_ channel: one item per transfer, a mailbox command or a service event
//     for one drive. Accepted when in_valid is high and in_stall is low.
//   out_ channel: exactly one result per item, in order, accepted when
//     out_valid is high and out_stall is low.
//   cfg_ channel: writes installed_mask; cfg_ready is always high. Write it
//     only while no item is in flight.
// Flow: the result register loads from the item register when it is empty
//   or its result is taken. Throughput: one item per cycle while out_stall
//   is low; the per-drive state is read and written as an item passes from
//   the item register to the result register, so consecutive items to the
//   same drive see each other's updates.
// Reset (rst_n low, synchronous): all drives ready, last command reset,
//   buffer address and block position zero, no pending interrupts, mask
//   clear, both pipeline stages empty.
// Stall: while out_stall holds a result, the block still takes one more
//   item into its item register, then raises in_stall.
`timescale 1ns / 1ps
`include "tape_device_controller_macros.svh"

module tape_device_controller import tdc_pkg::*; #(
  parameter int NUM_TAPES        = NUM_TAPES_DEF,
  parameter int BLOCK_INDEX_BITS = BLOCK_INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [IRQ_W-1:0]            cfg_data,
  // items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [TAPE_IDX_W-1:0]       in_tape_index,
  input  logic [OP_W-1:0]             in_tape_op,
  input  logic [ADDR_W-1:0]           in_buffer_address,
  input  logic                        in_transfer_ok,
  // results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [STATUS_W-1:0]         out_status_out,
  output logic [CMD_W-1:0]            out_command_out,
  output logic [ADDR_W-1:0]           out_data0_out,
  output logic                        out_data1_out,
  output logic                        out_mailbox_written,
  output logic [IRQ_W-1:0]            out_irq_pending,
  output logic                        out_timer_start,
  output logic                        out_transfer_request,
  output logic                        out_transfer_write,
  output logic [ADDR_W-1:0]           out_transfer_block
);

  localparam int SLOT_W = (NUM_TAPES > 1) ? $clog2(NUM_TAPES) : 1;
  localparam logic [TAPE_IDX_W:0] NUM_TAPES_V = (TAPE_IDX_W+1)'(NUM_TAPES);

  typedef logic [BLOCK_INDEX_BITS-1:0] blk_t;

  // pipeline control
  logic in_acc, adv;
  logic in_v_r, in_v_nxt;
  logic out_v_r, out_v_nxt;
  item_t item_r;

  // per-drive state
  logic [IRQ_W-1:0]  mask_r;
  status_t           status_r [NUM_TAPES];
  cmd_t              cmd_r    [NUM_TAPES];
  logic [ADDR_W-1:0] addr_r   [NUM_TAPES];
  blk_t              blk_r    [NUM_TAPES];
  logic [IRQ_W-1:0]  pend_r, pend_nxt;

  // current item view
  logic              present;
  logic [SLOT_W-1:0] slot;
  logic [IRQ_W-1:0]  bit_sel;
  status_t           cur_status;
  cmd_t              cur_cmd;
  logic [ADDR_W-1:0] cur_addr;
  blk_t              cur_blk;
  logic [ADDR_W-1:0] addr_nxt;
  exec_t             ex;

  // result registers
  status_t           res_status_r;
  cmd_t              res_cmd_r;
  logic [ADDR_W-1:0] res_data0_r;
  logic              res_data1_r;
  logic              res_written_r;
  logic              res_timer_r;
  logic              res_xreq_r;
  logic              res_xwr_r;
  blk_t              res_xblk_r;

  // handshakes
  assign cfg_ready = 1'b1;
  assign adv       = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign in_v_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : in_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_stall ? out_v_r : 1'b0);

  // drive lookup
  assign present    = ({1'b0, item_r.tape_index} < NUM_TAPES_V) && mask_r[item_r.tape_index];
  assign slot       = SLOT_W'(item_r.tape_index);
  assign bit_sel    = IRQ_W'(1) << item_r.tape_index;
  assign cur_status = status_r[slot];
  assign cur_cmd    = cmd_r[slot];
  assign cur_addr   = addr_r[slot];
  assign cur_blk    = blk_r[slot];

  tdc_exec u_exec (
    .item       (item_r),
    .present    (present),
    .cur_status (cur_status),
    .cur_cmd    (cur_cmd),
    .ex         (ex)
  );

  // updated buffer address and interrupt byte
  assign addr_nxt = ex.load_addr ? item_r.buffer_address : cur_addr;
  always_comb begin
    pend_nxt = pend_r;
    if (ex.int_set) begin
      pend_nxt = pend_nxt | bit_sel;
    end
    if (ex.int_clr) begin
      pend_nxt = pend_nxt & ~bit_sel;
    end
  end

  // control and drive state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      mask_r  <= '0;
      pend_r  <= '0;
      for (int i = 0; i < NUM_TAPES; i++) begin
        status_r[i] <= ST_READY;
        cmd_r[i]    <= CMD_RESET;
        addr_r[i]   <= '0;
        blk_r[i]    <= '0;
      end
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_data;
      end
      if (adv && present) begin
        status_r[slot] <= ex.status;
        cmd_r[slot]    <= ex.cmd;
        addr_r[slot]   <= addr_nxt;
        pend_r         <= pend_nxt;
        if (ex.blk_inc) begin
          blk_r[slot] <= cur_blk + BLOCK_INDEX_BITS'(1);
        end
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.command        <= in_command;
      item_r.tape_index     <= in_tape_index;
      item_r.tape_op        <= in_tape_op;
      item_r.buffer_address <= in_buffer_address;
      item_r.transfer_ok    <= in_transfer_ok;
    end
    if (adv) begin
      res_status_r  <= present ? ex.status : ST_ABSENT;
      res_cmd_r     <= present ? ex.cmd : CMD_RESET;
      res_data0_r   <= present ? addr_nxt : '0;
      res_data1_r   <= !present;
      res_written_r <= ex.written;
      res_timer_r   <= ex.timer;
      res_xreq_r    <= ex.xreq;
      res_xwr_r     <= ex.xwr;
      res_xblk_r    <= ex.xreq ? cur_blk : '0;
    end
  end

  // outputs
  assign out_valid            = out_v_r;
  assign out_status_out       = res_status_r;
  assign out_command_out      = res_cmd_r;
  assign out_data0_out        = res_data0_r;
  assign out_data1_out        = res_data1_r;
  assign out_mailbox_written  = res_written_r;
  assign out_irq_pending      = pend_r;
  assign out_timer_start      = res_timer_r;
  assign out_transfer_request = res_xreq_r;
  assign out_transfer_write   = res_xwr_r;
  assign out_transfer_block   = ADDR_W'(res_xblk_r);

  // checks
  `TDC_ASSERT(a_xfer_not_timer, !(out_valid && out_transfer_request && out_timer_start),
    "transfer and timer start in one result")
  `TDC_ASSERT(a_write_has_req, !(out_valid && out_transfer_write && !out_transfer_request),
    "transfer direction without transfer")
  `TDC_ASSERT(a_absent_quiet, !(out_valid && out_data1_out &&
    (out_status_out != ST_ABSENT || out_timer_start || out_transfer_request)),
    "absent drive result carries activity")
  `TDC_ASSERT_NEXT(a_item_held, in_v_r && !adv, in_v_r,
    "item dropped from the item register")

endmodule

FILE: sim/tb.sv
// testbench for tape_device_controller: directed table, then random phases under several masks
// depends on: tdc_pkg and the tape_device_controller rtl; results checked against a built-in model
`timescale 1ns / 1ps

module tb;
  import tdc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  // one expected result
  typedef struct {
    status_t                         status;
    cmd_t                            cmd;
    logic [ADDR_W-1:0]               data0;
    logic                            data1;
    logic                            written;
    logic [IRQ_W-1:0]                irq;
    logic                            timer;
    logic                            xreq;
    logic                            xwr;
    logic [BLOCK_INDEX_BITS_DEF-1:0] xblk;
  } tape_result_t;

  // one row of the directed table; is_cfg rows write mask instead of sending an item
  typedef struct {
    bit                    is_cfg;
    logic                  kind;
    logic [TAPE_IDX_W-1:0] idx;
    op_t                   op;
    logic [ADDR_W-1:0]     addr;
    logic                  ok;
    logic [IRQ_W-1:0]      mask;
    bit                    typed;
    status_t               st;
    logic                  wr;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [IRQ_W-1:0]                cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_command = 1'b0;
  logic [TAPE_IDX_W-1:0]           in_tape_index = '0;
  logic [OP_W-1:0]                 in_tape_op = '0;
  logic [ADDR_W-1:0]               in_buffer_address = '0;
  logic                            in_transfer_ok = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [STATUS_W-1:0]             out_status_out;
  logic [CMD_W-1:0]                out_command_out;
  logic [ADDR_W-1:0]               out_data0_out;
  logic                            out_data1_out;
  logic                            out_mailbox_written;
  logic [IRQ_W-1:0]                out_irq_pending;
  logic                            out_timer_start;
  logic                            out_transfer_request;
  logic                            out_transfer_write;
  logic [BLOCK_INDEX_BITS_DEF-1:0] out_transfer_block;

  // model of the drives
  status_t                         drv_status [8];
  cmd_t                            drv_cmd [8];
  logic [ADDR_W-1:0]               drv_addr [8];
  logic [BLOCK_INDEX_BITS_DEF-1:0] drv_pos [8];
  logic [IRQ_W-1:0]                irq_pending;
  logic [IRQ_W-1:0]                drv_mask;

  tape_result_t result_q [$];
  int err_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int burst_left = 1;

  logic [1:0] stall_mode = 2'd0;
  int mode_left = 0;

  // directed items: absent drives, every op, busy rules, illegal codes, address extremes
  plan_row_t dir_rows [28] = '{
    '{1'b1, KIND_MAILBOX, 3'd0, OP_RESET,    32'h0,        1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd0, OP_READREGS, 32'h0,        1'b0, 8'h00, 1'b1, ST_ABSENT,  1'b1},
    '{1'b0, KIND_MAILBOX, 3'd7, OP_SKIP,     32'h0,        1'b0, 8'h00, 1'b1, ST_ABSENT,  1'b0},
    '{1'b0, KIND_SERVICE, 3'd3, OP_RESET,    32'h0,        1'b1, 8'h00, 1'b1, ST_ABSENT,  1'b0},
    '{1'b1, KIND_MAILBOX, 3'd0, OP_RESET,    32'h0,        1'b0, 8'hFF, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd0, OP_READREGS, 32'h0,        1'b0, 8'h00, 1'b1, ST_READY,   1'b1},
    '{1'b0, KIND_MAILBOX, 3'd0, OP_READ,     32'hFFFFFFFF, 1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd0, OP_WRITE,    32'h12345678, 1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd0, OP_ACK,      32'h0,        1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_SERVICE, 3'd0, OP_RESET,    32'h0,        1'b1, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_SERVICE, 3'd0, OP_RESET,    32'h0,        1'b1, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd0, OP_ACK,      32'h0,        1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd1, OP_WRITE,    32'h0,        1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_SERVICE, 3'd1, OP_RESET,    32'h0,        1'b0, 8'h00, 1'b1, ST_RDERR,   1'b1},
    '{1'b0, KIND_MAILBOX, 3'd2, OP_SKIP,     32'hFFFFFFFF, 1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_SERVICE, 3'd2, OP_RESET,    32'h0,        1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd2, OP_READ,     32'hA5A5A5A5, 1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_SERVICE, 3'd2, OP_RESET,    32'h0,        1'b1, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd3, 8'hFF,       32'h0,        1'b0, 8'h00, 1'b1, ST_ILLEGAL, 1'b1},
    '{1'b0, KIND_MAILBOX, 3'd3, 8'h06,       32'h0,        1'b0, 8'h00, 1'b1, ST_ILLEGAL, 1'b1},
    '{1'b0, KIND_MAILBOX, 3'd4, OP_SKIP,     32'h0,        1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd4, 8'h80,       32'h0,        1'b0, 8'h00, 1'b1, ST_ILLEGAL, 1'b1},
    '{1'b0, KIND_SERVICE, 3'd4, OP_RESET,    32'h0,        1'b1, 8'h00, 1'b1, ST_ILLEGAL, 1'b0},
    '{1'b0, KIND_MAILBOX, 3'd5, OP_READ,     32'h5A5A5A5A, 1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd5, OP_RESET,    32'h0,        1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_SERVICE, 3'd5, OP_RESET,    32'h0,        1'b1, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_MAILBOX, 3'd6, OP_WRITE,    32'hFFFFFFFF, 1'b0, 8'h00, 1'b0, ST_ABSENT,  1'b0},
    '{1'b0, KIND_SERVICE, 3'd6, OP_RESET,    32'h0,        1'b1, 8'h00, 1'b0, ST_ABSENT,  1'b0}
  };

  tape_device_controller uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_tape_index       (in_tape_index),
    .in_tape_op          (in_tape_op),
    .in_buffer_address   (in_buffer_address),
    .in_transfer_ok      (in_transfer_ok),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status_out      (out_status_out),
    .out_command_out     (out_command_out),
    .out_data0_out       (out_data0_out),
    .out_data1_out       (out_data1_out),
    .out_mailbox_written (out_mailbox_written),
    .out_irq_pending     (out_irq_pending),
    .out_timer_start     (out_timer_start),
    .out_transfer_request(out_transfer_request),
    .out_transfer_write  (out_transfer_write),
    .out_transfer_block  (out_transfer_block)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern: free, light random, periodic on cycle_count, heavy random
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= 2'($urandom_range(3));
      mode_left <= $urandom_range(20, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(3) == 0);
      2'd2: out_stall <= (cycle_count % 3 == 0);
      default: out_stall <= ($urandom_range(7) != 0);
    endcase
  end

  // next drive state and result for one accepted item
  function automatic tape_result_t tape_predict(item_t it);
    tape_result_t r;
    logic present;
    logic [IRQ_W-1:0] bitm;
    status_t st;
    int t;
    t = it.tape_index;
    present = drv_mask[t];
    bitm = 8'b1 << t;
    r.written = 1'b0;
    r.timer = 1'b0;
    r.xreq = 1'b0;
    r.xwr = 1'b0;
    r.xblk = '0;
    if (!present) begin
      if (it.command == KIND_MAILBOX && it.tape_op == OP_READREGS) r.written = 1'b1;
    end else if (it.command == KIND_MAILBOX) begin
      st = drv_status[t];
      r.written = 1'b1;
      case (it.tape_op)
        OP_RESET: begin
          drv_cmd[t] = CMD_RESET;
          drv_status[t] = ST_READY;
        end
        OP_ACK: if (st != ST_BUSY) begin
          drv_cmd[t] = CMD_ACK;
          drv_status[t] = ST_READY;
          irq_pending = irq_pending & ~bitm;
        end
        OP_READREGS: ;
        OP_SKIP: if (st != ST_BUSY) begin
          drv_cmd[t] = CMD_SKIP;
          drv_status[t] = ST_BUSY;
          r.timer = 1'b1;
        end
        OP_READ: if (st != ST_BUSY) begin
          drv_cmd[t] = CMD_READ;
          drv_addr[t] = it.buffer_address;
          drv_status[t] = ST_BUSY;
          r.timer = 1'b1;
        end
        OP_WRITE: if (st != ST_BUSY) begin
          drv_cmd[t] = CMD_WRITE;
          drv_addr[t] = it.buffer_address;
          drv_status[t] = ST_BUSY;
          r.timer = 1'b1;
        end
        default: drv_status[t] = ST_ILLEGAL;
      endcase
    end else if (drv_status[t] == ST_BUSY) begin
      // service finishes the pending command
      case (drv_cmd[t])
        CMD_SKIP: begin
          drv_pos[t] = drv_pos[t] + 1'b1;
          drv_status[t] = ST_READY;
          irq_pending = irq_pending | bitm;
          r.written = 1'b1;
        end
        CMD_READ, CMD_WRITE: begin
          r.xreq = 1'b1;
          r.xwr = (drv_cmd[t] == CMD_WRITE);
          r.xblk = drv_pos[t];
          if (it.transfer_ok) begin
            drv_status[t] = ST_READY;
            irq_pending = irq_pending | bitm;
          end else begin
            drv_status[t] = ST_RDERR;
          end
          r.written = 1'b1;
        end
        default: ;
      endcase
    end
    if (present) begin
      r.status = drv_status[t];
      r.cmd = drv_cmd[t];
      r.data0 = drv_addr[t];
      r.data1 = 1'b0;
    end else begin
      r.status = ST_ABSENT;
      r.cmd = CMD_RESET;
      r.data0 = '0;
      r.data1 = 1'b1;
    end
    r.irq = irq_pending;
    return r;
  endfunction

  // random set bit of a nonzero drive set
  function automatic logic [TAPE_IDX_W-1:0] pick_drive(logic [IRQ_W-1:0] pool);
    int k;
    k = $urandom_range($countones(pool) - 1);
    for (int t = 0; t < 8; t++) begin
      if (pool[t]) begin
        if (k == 0) return TAPE_IDX_W'(t);
        k--;
      end
    end
    return '0;
  endfunction

  // mostly commands to present drives and services of busy ones, some noise
  function automatic item_t make_item();
    item_t it;
    logic [IRQ_W-1:0] busy;
    int sel;
    busy = '0;
    for (int t = 0; t < 8; t++) busy[t] = drv_mask[t] && (drv_status[t] == ST_BUSY);
    it.command = KIND_MAILBOX;
    it.tape_index = TAPE_IDX_W'($urandom_range(7));
    it.tape_op = OP_READREGS;
    it.buffer_address = $urandom;
    it.transfer_ok = ($urandom_range(3) != 0);
    sel = $urandom_range(99);
    if (sel < 35) begin
      it.command = KIND_SERVICE;
      it.tape_op = op_t'($urandom_range(255));
      if (busy != 0 && $urandom_range(3) != 0) it.tape_index = pick_drive(busy);
    end else if (sel < 95) begin
      if (drv_mask != 0 && $urandom_range(4) != 0) it.tape_index = pick_drive(drv_mask);
      if (sel < 85) it.tape_op = op_t'($urandom_range(OP_RESET, OP_WRITE));
      else it.tape_op = op_t'($urandom_range(OP_WRITE + 1, 255));
    end else begin
      it.command = 1'($urandom_range(1));
      it.tape_op = op_t'($urandom_range(255));
    end
    return it;
  endfunction

  // one item transfer, then the burst or gap that follows it
  task automatic push_item(item_t it, bit typed, status_t st, logic wr);
    tape_result_t want;
    in_valid <= 1'b1;
    in_command <= it.command;
    in_tape_index <= it.tape_index;
    in_tape_op <= it.tape_op;
    in_buffer_address <= it.buffer_address;
    in_transfer_ok <= it.transfer_ok;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    want = tape_predict(it);
    if (typed) begin
      want.status = st;
      want.written = wr;
    end
    result_q.push_back(want);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // sender holds off until every expected result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // installed mask write, only with nothing in flight
  task automatic write_mask(logic [IRQ_W-1:0] m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    drv_mask = m;
  endtask

  task automatic note_mismatch(string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // result transfer happens at the next rising edge; outputs are stable here
  always @(negedge clk) begin : result_check
    tape_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (result_q.size() == 0) begin
        note_mismatch("result with nothing expected");
      end else begin
        want = result_q.pop_front();
        check_field("status_out", out_status_out, want.status);
        check_field("command_out", out_command_out, want.cmd);
        check_field("data0_out", out_data0_out, want.data0);
        check_field("data1_out", out_data1_out, want.data1);
        check_field("mailbox_written", out_mailbox_written, want.written);
        check_field("irq_pending", out_irq_pending, want.irq);
        check_field("timer_start", out_timer_start, want.timer);
        check_field("transfer_request", out_transfer_request, want.xreq);
        check_field("transfer_write", out_transfer_write, want.xwr);
        check_field("transfer_block", out_transfer_block, want.xblk);
      end
    end
  end

  // stimulus
  initial begin : stim
    item_t it;
    logic [IRQ_W-1:0] m;
    for (int t = 0; t < 8; t++) begin
      drv_status[t] = ST_READY;
      drv_cmd[t] = CMD_RESET;
      drv_addr[t] = '0;
      drv_pos[t] = '0;
    end
    irq_pending = '0;
    drv_mask = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < $size(dir_rows); i++) begin
      if (dir_rows[i].is_cfg) begin
        write_mask(dir_rows[i].mask);
      end else begin
        it.command = dir_rows[i].kind;
        it.tape_index = dir_rows[i].idx;
        it.tape_op = dir_rows[i].op;
        it.buffer_address = dir_rows[i].addr;
        it.transfer_ok = dir_rows[i].ok;
        push_item(it, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].wr);
      end
    end

    // random phases: all drives, none, then random masks
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: m = 8'hFF;
        1: m = 8'h00;
        default: m = IRQ_W'($urandom_range(1, 254));
      endcase
      write_mask(m);
      for (int n = 0; n < ((ph == 1) ? 40 : 100); n++) begin
        if (ph == 2 && n == 50) wait_idle();
        push_item(make_item(), 1'b0, ST_ABSENT, 1'b0);
      end
    end

    // drain, then wait for stray results
    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
